### design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define OLIST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("olist property violated");

// condition that must never be seen outside reset
`define OLIST_NEVER(lbl, cond) \
    `OLIST_ASSERT(lbl, !(cond))

`endif

### design/olist_pkg.sv
// types, constants and field layout for the ordered record list
package olist_pkg;

    localparam int CAPACITY   = 16;
    localparam int NAME_BYTES = 8;

    localparam int ACTION_W = 2;
    localparam int POS_W    = 5;
    localparam int NAME_W   = 64;
    localparam int ID_W     = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam int IN_NAME_LSB  = POS_W;
    localparam int IN_ID_LSB    = POS_W + NAME_W;
    localparam int IN_USED_W    = POS_W + NAME_W + ID_W;
    localparam int OUT_USED_W   = COUNT_W + NAME_W + ID_W;
    localparam int TDATA_W      = ((IN_USED_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);
    localparam logic [NAME_W-1:0]  NAME_KEEP =
        ~({NAME_W{1'b1}} >> (8 * NAME_BYTES));

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        action_t                  action;
        logic [POS_W-1:0]         position;
        logic [NAME_W-1:0]        name_code;
        logic signed [ID_W-1:0]   id_number;
    } item_t;

    typedef struct packed {
        status_t                  status;
        logic [COUNT_W-1:0]       entry_count;
        logic [NAME_W-1:0]        read_name;
        logic signed [ID_W-1:0]   read_id;
    } result_t;

    typedef struct packed {
        logic [NAME_W-1:0]        name;
        logic signed [ID_W-1:0]   id;
    } entry_t;

    // handshake between the stages
    typedef struct packed {
        logic                     valid;
        logic                     advance;
    } stage_ctl_t;

endpackage

### design/ordered_list_insert_remove_at_index.sv
// top level of the ordered record list with insert, remove and read at index
//
//  channel  dir  tdata (low bit up)                        tuser
//  s_*      in   position, name_code, id_number, zero pad  action
//  m_*      out  entry_count, read_name, read_id, zero pad status
//
//  one transaction per cycle sustained while m_tready is high, result via input and result registers
//  the whole list register row updates at once for each transaction
//  rst_n clears the record count and both valid flags, no clearing pass
//  a stall on m_tready holds the result register and, once it is full, the input register
module ordered_list_insert_remove_at_index (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // position, name_code, id_number, zero pad
    input  logic [olist_pkg::TDATA_W-1:0]     s_tdata,
    // action
    input  logic [olist_pkg::ACTION_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // entry_count, read_name, read_id, zero pad
    output logic [olist_pkg::TDATA_W-1:0]     m_tdata,
    // status
    output logic [olist_pkg::STATUS_W-1:0]    m_tuser
);

    olist_pkg::stage_ctl_t  ctl;
    olist_pkg::item_t       item;
    olist_pkg::result_t     result;
    logic                   advance;

    olist_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .advance  (advance),
        .ctl      (ctl),
        .item     (item)
    );

    olist_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .item   (item),
        .result (result)
    );

    olist_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (ctl.valid),
        .result     (result),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

### design/olist_in_stage.sv
// input register stage: unpacks and holds one incoming transaction
module olist_in_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [olist_pkg::TDATA_W-1:0]     s_tdata,
    input  logic [olist_pkg::ACTION_W-1:0]    s_tuser,
    input  logic                              advance,
    output olist_pkg::stage_ctl_t             ctl,
    output olist_pkg::item_t                  item
);

    logic              valid_reg;
    logic              valid_next;
    olist_pkg::item_t  item_reg;
    logic              take;

    assign s_tready   = !valid_reg || advance;
    assign take       = s_tvalid && s_tready;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.action    <= olist_pkg::action_t'(s_tuser);
            item_reg.position  <= s_tdata[olist_pkg::POS_W-1:0];
            item_reg.name_code <= s_tdata[olist_pkg::IN_ID_LSB-1:olist_pkg::IN_NAME_LSB];
            item_reg.id_number <= s_tdata[olist_pkg::IN_USED_W-1:olist_pkg::IN_ID_LSB];
        end
    end

    assign ctl.valid   = valid_reg;
    assign ctl.advance = advance;
    assign item        = item_reg;

endmodule

### design/olist_core.sv
// record list storage with parallel shift on insert and remove
module olist_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  olist_pkg::stage_ctl_t  ctl,
    input  olist_pkg::item_t       item,
    output olist_pkg::result_t     result
);

    olist_pkg::entry_t                  entry_reg [olist_pkg::CAPACITY];
    olist_pkg::entry_t                  entry_next [olist_pkg::CAPACITY];
    logic [olist_pkg::COUNT_W-1:0]      count_reg;
    logic [olist_pkg::COUNT_W-1:0]      count_next;
    olist_pkg::entry_t                  new_entry;
    olist_pkg::entry_t                  hit;
    logic                               fire;

    assign fire = ctl.valid && ctl.advance;

    always_comb
    begin
        entry_next         = entry_reg;
        count_next         = count_reg;
        result.status      = olist_pkg::ST_DONE;
        result.read_name   = '0;
        result.read_id     = '0;
        new_entry.name     = item.name_code & olist_pkg::NAME_KEEP;
        new_entry.id       = item.id_number;
        hit                = entry_reg[item.position[olist_pkg::IDX_W-1:0]];

        unique case (item.action)
            olist_pkg::ACT_INSERT:
            begin
                if (item.position > count_reg)
                begin
                    result.status = olist_pkg::ST_RANGE;
                end
                else if (count_reg >= olist_pkg::CAP_COUNT)
                begin
                    result.status = olist_pkg::ST_FULL;
                end
                else
                begin
                    if (item.position == '0)
                    begin
                        entry_next[0] = new_entry;
                    end
                    for (int i = 1; i < olist_pkg::CAPACITY; i++)
                    begin
                        if (olist_pkg::POS_W'(i) == item.position)
                        begin
                            entry_next[i] = new_entry;
                        end
                        else if (olist_pkg::POS_W'(i) > item.position)
                        begin
                            entry_next[i] = entry_reg[i-1];
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            olist_pkg::ACT_REMOVE,
            olist_pkg::ACT_READ:
            begin
                if (count_reg == '0)
                begin
                    result.status = olist_pkg::ST_EMPTY;
                end
                else if (item.position >= count_reg)
                begin
                    result.status = olist_pkg::ST_RANGE;
                end
                else
                begin
                    result.read_name = hit.name;
                    result.read_id   = hit.id;
                    if (item.action == olist_pkg::ACT_REMOVE)
                    begin
                        for (int i = 0; i < olist_pkg::CAPACITY - 1; i++)
                        begin
                            if (olist_pkg::POS_W'(i) >= item.position)
                            begin
                                entry_next[i] = entry_reg[i+1];
                            end
                        end
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            olist_pkg::ACT_NONE:
            begin
            end
        endcase

        result.entry_count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (fire)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

### design/olist_out_stage.sv
// result register stage: holds and packs one outgoing transaction
module olist_out_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load_valid,
    input  olist_pkg::result_t                result,
    output logic                              advance,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [olist_pkg::TDATA_W-1:0]     m_tdata,
    output logic [olist_pkg::STATUS_W-1:0]    m_tuser
);

    logic                valid_reg;
    logic                valid_next;
    olist_pkg::result_t  result_reg;
    logic                load;

    assign advance    = !valid_reg || m_tready;
    assign load       = load_valid && advance;
    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = result_reg.status;
    assign m_tdata  = olist_pkg::TDATA_W'({result_reg.read_id, result_reg.read_name,
                                           result_reg.entry_count});

endmodule

### design/olist_checker.sv
// port-level checks for the ordered record list, bound to the top level
`include "assert_macros.svh"

module olist_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [olist_pkg::TDATA_W-1:0]     s_tdata,
    input  logic [olist_pkg::ACTION_W-1:0]    s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [olist_pkg::TDATA_W-1:0]     m_tdata,
    input  logic [olist_pkg::STATUS_W-1:0]    m_tuser
);

    logic [olist_pkg::COUNT_W-1:0]                     out_count;
    logic [olist_pkg::STATUS_W+olist_pkg::TDATA_W-1:0] out_word;
    logic                                              is_full;
    logic                                              is_empty;
    logic                                              refused;
    logic                                              payload_zero;

    assign out_count    = m_tdata[olist_pkg::COUNT_W-1:0];
    assign out_word     = {m_tuser, m_tdata};
    assign is_full      = m_tuser == olist_pkg::ST_FULL;
    assign is_empty     = m_tuser == olist_pkg::ST_EMPTY;
    assign refused      = (m_tuser == olist_pkg::ST_RANGE) || is_empty || is_full;
    assign payload_zero = m_tdata[olist_pkg::OUT_USED_W-1:olist_pkg::COUNT_W] == '0;

    `OLIST_NEVER(a_count_in_range, m_tvalid && (out_count > olist_pkg::CAP_COUNT))
    `OLIST_ASSERT(a_full_count, m_tvalid && is_full |-> out_count == olist_pkg::CAP_COUNT)
    `OLIST_ASSERT(a_empty_count, m_tvalid && is_empty |-> out_count == '0)
    `OLIST_ASSERT(a_refused_zero, m_tvalid && refused |-> payload_zero)
    `OLIST_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(out_word))

endmodule

bind ordered_list_insert_remove_at_index olist_checker u_olist_checker (.*);

### verif/tb_ordered_list_insert_remove_at_index.sv
// testbench for the ordered record list: insert, remove and read at an index
`timescale 1ns / 1ps

module tb_ordered_list_insert_remove_at_index;

    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 11;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int RECV_HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES     = 8;
    localparam int REPORT_LIMIT     = 10;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [olist_pkg::TDATA_W-1:0]       s_tdata = '0;
    logic [olist_pkg::ACTION_W-1:0]      s_tuser = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [olist_pkg::TDATA_W-1:0]       m_tdata;
    logic [olist_pkg::STATUS_W-1:0]      m_tuser;

    olist_pkg::item_t                    pending_items[$];
    olist_pkg::result_t                  expected_results[$];
    olist_pkg::item_t                    drv_item;

    logic [olist_pkg::NAME_W-1:0]        list_names[olist_pkg::CAPACITY];
    logic signed [olist_pkg::ID_W-1:0]   list_ids[olist_pkg::CAPACITY];
    int                                  list_count = 0;
    int                                  gen_count = 0;

    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    recv_hold_reqs = 0;
    int                    recv_hold_served = 0;
    int                    recv_hold_left = 0;

    int                    items_sent = 0;
    int                    items_taken = 0;
    int                    results_checked = 0;
    int                    mismatches = 0;
    int                    status_hits[4] = '{0, 0, 0, 0};

    ordered_list_insert_remove_at_index u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic olist_pkg::result_t predict_list_action(olist_pkg::item_t it);
        olist_pkg::result_t           res;
        logic [olist_pkg::NAME_W-1:0] keep;
        int                           pos;
        int                           i;
        keep = (olist_pkg::NAME_BYTES >= 8) ? {olist_pkg::NAME_W{1'b1}} :
               ~({olist_pkg::NAME_W{1'b1}} >> (8 * olist_pkg::NAME_BYTES));
        pos = int'(it.position);
        res.status    = olist_pkg::ST_DONE;
        res.read_name = '0;
        res.read_id   = '0;
        case (it.action)
            olist_pkg::ACT_INSERT:
            begin
                if (pos > list_count)
                    res.status = olist_pkg::ST_RANGE;
                else if (list_count >= olist_pkg::CAPACITY)
                    res.status = olist_pkg::ST_FULL;
                else
                begin
                    for (i = list_count; i > pos; i--)
                    begin
                        list_names[i] = list_names[i-1];
                        list_ids[i]   = list_ids[i-1];
                    end
                    list_names[pos] = it.name_code & keep;
                    list_ids[pos]   = it.id_number;
                    list_count++;
                end
            end
            olist_pkg::ACT_REMOVE, olist_pkg::ACT_READ:
            begin
                if (list_count == 0)
                    res.status = olist_pkg::ST_EMPTY;
                else if (pos >= list_count)
                    res.status = olist_pkg::ST_RANGE;
                else
                begin
                    res.read_name = list_names[pos];
                    res.read_id   = list_ids[pos];
                    if (it.action == olist_pkg::ACT_REMOVE)
                    begin
                        for (i = pos; i + 1 < list_count; i++)
                        begin
                            list_names[i] = list_names[i+1];
                            list_ids[i]   = list_ids[i+1];
                        end
                        list_count--;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.entry_count = olist_pkg::COUNT_W'(list_count);
        return res;
    endfunction

    // input side
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || items_taken == items_sent)
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                drv_item = pending_items.pop_front();
                items_sent++;
                s_tvalid <= 1'b1;
                s_tdata  <= olist_pkg::TDATA_W'({drv_item.id_number, drv_item.name_code,
                                                 drv_item.position});
                s_tuser  <= drv_item.action;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // output side ready, with the long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (recv_hold_reqs != recv_hold_served)
        begin
            recv_hold_served = recv_hold_reqs;
            recv_hold_left   = RECV_HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (recv_hold_left > 0)
        begin
            recv_hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        olist_pkg::result_t want;
        olist_pkg::result_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                want = predict_list_action(drv_item);
                expected_results.push_back(want);
                status_hits[want.status]++;
                items_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                got.status      = olist_pkg::status_t'(m_tuser);
                got.entry_count = m_tdata[olist_pkg::COUNT_W-1:0];
                got.read_name   = m_tdata[olist_pkg::COUNT_W +: olist_pkg::NAME_W];
                got.read_id     = m_tdata[olist_pkg::COUNT_W + olist_pkg::NAME_W +:
                                          olist_pkg::ID_W];
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result transaction: status %0d count %0d",
                                 got.status, got.entry_count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got.status !== want.status || got.entry_count !== want.entry_count
                        || got.read_name !== want.read_name || got.read_id !== want.read_id)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"mismatch on result %0d: status exp %0d got %0d, ",
                                      "count exp %0d got %0d, name exp %h got %h, ",
                                      "id exp %0d got %0d"},
                                     results_checked, want.status, got.status,
                                     want.entry_count, got.entry_count,
                                     want.read_name, got.read_name,
                                     want.read_id, got.read_id);
                    end
                end
            end
        end
    end

    // run limit
    initial
    begin
        int cycle_count;
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    task automatic push_action(olist_pkg::action_t act, int pos,
                               logic [olist_pkg::NAME_W-1:0] name,
                               logic [olist_pkg::ID_W-1:0] id);
        olist_pkg::item_t it;
        it.action    = act;
        it.position  = olist_pkg::POS_W'(pos);
        it.name_code = name;
        it.id_number = id;
        case (act)
            olist_pkg::ACT_INSERT:
                if (pos <= gen_count && gen_count < olist_pkg::CAPACITY)
                    gen_count++;
            olist_pkg::ACT_REMOVE:
                if (gen_count > 0 && pos < gen_count)
                    gen_count--;
            default:
            begin
            end
        endcase
        pending_items.push_back(it);
    endtask

    task automatic queue_actions(int count, int insert_pct, int remove_pct);
        int                           n;
        int                           r;
        int                           pos;
        olist_pkg::action_t           act;
        logic [olist_pkg::NAME_W-1:0] name;
        logic [olist_pkg::ID_W-1:0]   id;
        for (n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < insert_pct)
                act = olist_pkg::ACT_INSERT;
            else if (r < insert_pct + remove_pct)
                act = olist_pkg::ACT_REMOVE;
            else if (r < 97)
                act = olist_pkg::ACT_READ;
            else
                act = olist_pkg::ACT_NONE;
            // some positions land anywhere the field allows
            if ($urandom_range(99) < 8)
                pos = $urandom_range(31, 0);
            else if (act == olist_pkg::ACT_INSERT)
                pos = $urandom_range(gen_count, 0);
            else if (gen_count > 0)
                pos = $urandom_range(gen_count - 1, 0);
            else
                pos = 0;
            case ($urandom_range(9))
                0: name = '0;
                1: name = '1;
                default: name = {$urandom, $urandom};
            endcase
            case ($urandom_range(9))
                0: id = 32'h8000_0000;
                1: id = 32'h7fff_ffff;
                default: id = $urandom;
            endcase
            push_action(act, pos, name, id);
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty list, bad positions, both ends, middle, unused action
        push_action(olist_pkg::ACT_READ,   0,  64'h0123_4567_89ab_cdef, 32'h1);
        push_action(olist_pkg::ACT_REMOVE, 0,  64'h0,                   32'h0);
        push_action(olist_pkg::ACT_NONE,   0,  64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
        push_action(olist_pkg::ACT_INSERT, 1,  64'h4142_4344_4546_4748, 32'h5);
        push_action(olist_pkg::ACT_INSERT, 0,  64'hffff_ffff_ffff_ffff, 32'h8000_0000);
        push_action(olist_pkg::ACT_INSERT, 1,  64'h0,                   32'h7fff_ffff);
        push_action(olist_pkg::ACT_INSERT, 1,  64'h416c_6963_6500_0000, 32'hffff_ffff);
        push_action(olist_pkg::ACT_INSERT, 31, 64'h1111_2222_3333_4444, 32'h0);
        push_action(olist_pkg::ACT_INSERT, 3,  64'h426f_6200_0000_0000, 32'h0);
        push_action(olist_pkg::ACT_READ,   0,  64'h0,                   32'h0);
        push_action(olist_pkg::ACT_READ,   3,  64'h0,                   32'h0);
        push_action(olist_pkg::ACT_READ,   4,  64'h0,                   32'h0);
        push_action(olist_pkg::ACT_READ,   31, 64'h0,                   32'h0);
        push_action(olist_pkg::ACT_REMOVE, 1,  64'h0,                   32'h0);
        push_action(olist_pkg::ACT_REMOVE, 2,  64'h0,                   32'h0);
        push_action(olist_pkg::ACT_REMOVE, 16, 64'h0,                   32'h0);
        push_action(olist_pkg::ACT_NONE,   17, 64'h0,                   32'h0);
        push_action(olist_pkg::ACT_READ,   1,  64'h0,                   32'h0);
        wait_drained();

        // no idling, fill-heavy so the list hits full
        queue_actions(150, 65, 15);
        wait_drained();

        send_idle_pct = 54;
        queue_actions(150, 40, 40);
        wait_drained();

        // receiver stalls, plus a long hold-off while items keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 54;
        queue_actions(150, 50, 30);
        recv_hold_reqs++;
        wait_drained();

        // both sides idle, drain-heavy so the list empties again
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        queue_actions(150, 30, 50);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            mismatches++;

        $display("covered %0d list actions, %0d results compared, %0d mismatches",
                 items_taken, results_checked, mismatches);
        $display("outcomes: done %0d, out of range %0d, empty %0d, full %0d",
                 status_hits[olist_pkg::ST_DONE], status_hits[olist_pkg::ST_RANGE],
                 status_hits[olist_pkg::ST_EMPTY], status_hits[olist_pkg::ST_FULL]);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/olist_pkg.sv
design/olist_in_stage.sv
design/olist_core.sv
design/olist_out_stage.sv
design/ordered_list_insert_remove_at_index.sv
design/olist_checker.sv
verif/tb_ordered_list_insert_remove_at_index.sv
